@@ rtl/cmmd_pkg.sv @@
// ----------------------------------------------------------------------------
// cmmd_pkg - shared types and constants for column min/max decimation
// Coordinate width, stream widths and the flush job carried between the
// front and back parts.
// ----------------------------------------------------------------------------
package cmmd_pkg;

    // coordinate width of x and y
    localparam int COORD_BITS = 16;
    // stream payload width: x and y packed, padded up to whole bytes
    localparam int DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int PAD_BITS   = DATA_BITS - 2 * COORD_BITS;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [DATA_BITS-1:0]  data_t;

    // one column to be flushed
    typedef struct packed {
        coord_t x;
        coord_t low_y;
        coord_t high_y;
        coord_t latest_y;
    } cmmd_flush_t;

    // everything one input item causes: an optional flush of the old column
    // and an optional flush of the current column on the end mark
    typedef struct packed {
        logic        has_a;
        cmmd_flush_t a;
        logic        has_b;
        cmmd_flush_t b;
    } cmmd_job_t;

    // point position within one flush
    typedef enum logic [1:0] {
        PT_LOW    = 2'd0,
        PT_HIGH   = 2'd1,
        PT_LATEST = 2'd2
    } cmmd_pt_t;

endpackage

@@ rtl/cmmd_front.sv @@
// ----------------------------------------------------------------------------
// cmmd_front - input acceptance and column tracking
// Keeps the open column's extremes and latest y, and turns each item that
// closes a column into one flush job for the queue.
// ----------------------------------------------------------------------------
module cmmd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cmmd_pkg::data_t     s_tdata,    // [x, y] from the low bits up
    input  logic                s_tlast,    // end of stream
    input  logic                queue_full,
    output logic                push,
    output cmmd_pkg::cmmd_job_t push_job
);
    import cmmd_pkg::*;

    coord_t x_reg, low_reg, high_reg, latest_reg;
    coord_t low_next, high_next;
    logic   open_reg;
    coord_t in_x, in_y;
    logic   accept, flush_a, fresh;

    assign in_x     = s_tdata[COORD_BITS-1:0];
    assign in_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // a new x closes the open column
    assign flush_a = open_reg && (in_x != x_reg);
    assign fresh   = !open_reg || flush_a;

    // first extreme wins on ties
    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        if (fresh) begin
            low_next  = in_y;
            high_next = in_y;
        end else if (in_y < low_reg) begin
            low_next  = in_y;
        end else if (in_y > high_reg) begin
            high_next = in_y;
        end
    end

    // flush job for this item
    always_comb begin
        push_job.has_a      = flush_a;
        push_job.a.x        = x_reg;
        push_job.a.low_y    = low_reg;
        push_job.a.high_y   = high_reg;
        push_job.a.latest_y = latest_reg;
        push_job.has_b      = s_tlast;
        push_job.b.x        = in_x;
        push_job.b.low_y    = low_next;
        push_job.b.high_y   = high_next;
        push_job.b.latest_y = in_y;
    end

    assign push = accept && (flush_a || s_tlast);

    // column state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg   <= 1'b0;
            x_reg      <= '0;
            low_reg    <= '0;
            high_reg   <= '0;
            latest_reg <= '0;
        end else if (accept) begin
            open_reg   <= !s_tlast;
            x_reg      <= in_x;
            low_reg    <= low_next;
            high_reg   <= high_next;
            latest_reg <= in_y;
        end
    end

endmodule

@@ rtl/cmmd_queue.sv @@
// ----------------------------------------------------------------------------
// cmmd_queue - short job queue between front and back
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module cmmd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  cmmd_pkg::cmmd_job_t push_job,
    input  logic                pop,
    output cmmd_pkg::cmmd_job_t head_job,
    output logic                empty,
    output logic                full
);
    import cmmd_pkg::*;

    cmmd_job_t            mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic                 do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/cmmd_back.sv @@
// ----------------------------------------------------------------------------
// cmmd_back - flush sequencer and output register
// Walks the head job point by point (per flush: low and high if they differ,
// then latest) and drives the result stream through a registered output.
// ----------------------------------------------------------------------------
module cmmd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  cmmd_pkg::cmmd_job_t head_job,
    input  logic                empty,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output cmmd_pkg::data_t     m_tdata,    // [x, y] from the low bits up
    output logic                m_tlast     // last result of the item
);
    import cmmd_pkg::*;

    logic        half_reg;      // 0 = old column flush, 1 = end-mark flush
    cmmd_pt_t    pt_reg;
    logic        valid_reg, last_reg;
    data_t       data_reg;

    logic        eff_half;
    cmmd_pt_t    eff_pt;
    cmmd_flush_t cur;
    coord_t      cur_y;
    logic        differ, load, end_flush, end_job;

    // current flush and point, skipping absent parts
    assign eff_half = half_reg || !head_job.has_a;
    assign cur      = eff_half ? head_job.b : head_job.a;
    assign differ   = (cur.low_y != cur.high_y);
    assign eff_pt   = differ ? pt_reg : PT_LATEST;

    always_comb begin
        unique case (eff_pt)
            PT_LOW:  cur_y = cur.low_y;
            PT_HIGH: cur_y = cur.high_y;
            default: cur_y = cur.latest_y;
        endcase
    end

    assign end_flush = (eff_pt == PT_LATEST);
    assign end_job   = end_flush && (eff_half || !head_job.has_b);
    assign load      = !empty && (!valid_reg || m_tready);
    assign pop       = load && end_job;

    // sequencer position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg <= 1'b0;
            pt_reg   <= PT_LOW;
        end else if (load) begin
            if (end_job) begin
                half_reg <= 1'b0;
                pt_reg   <= PT_LOW;
            end else if (end_flush) begin
                half_reg <= 1'b1;
                pt_reg   <= PT_LOW;
            end else begin
                pt_reg   <= (eff_pt == PT_LOW) ? PT_HIGH : PT_LATEST;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_t'({cur_y, cur.x});
            last_reg <= end_job;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

@@ rtl/column_min_max_decimation_top.sv @@
// Path: the first result of an item goes through the job queue and then
// through the output register.
// Throughput: one item per cycle while the 4-entry job queue has room; the
// back end emits one result per unstalled cycle; a 6-result job paces it.
// Reset: synchronous active-low aresetn clears column state, queue and output.
// ----------------------------------------------------------------------------
// column_min_max_decimation_top - column min/max decimation of plot points
// Front tracks columns and queues flush jobs, back serializes the results.
// ----------------------------------------------------------------------------
module column_min_max_decimation_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  cmmd_pkg::data_t  s_tdata,   // [in_x, in_y] from the low bits up
    input  logic             s_tlast,   // end_of_stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output cmmd_pkg::data_t  m_tdata,   // [out_x, out_y] from the low bits up
    output logic             m_tlast    // last_of_run
);
    import cmmd_pkg::*;

    logic      push, pop, empty, full;
    cmmd_job_t push_job, head_job;

    cmmd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    cmmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .empty    (empty),
        .full     (full)
    );

    cmmd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/cmmd_checker.sv @@
// ----------------------------------------------------------------------------
// cmmd_checker - port-level checks for column min/max decimation
// Mirrors column state from the input stream and counts items whose
// results are still owed.
// ----------------------------------------------------------------------------
module cmmd_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input cmmd_pkg::data_t  s_tdata,
    input logic             s_tlast,
    input logic             m_tvalid,
    input logic             m_tready,
    input cmmd_pkg::data_t  m_tdata,
    input logic             m_tlast
);
    import cmmd_pkg::*;

    logic   open_reg;
    coord_t x_reg;
    logic [3:0] pending_reg;
    logic   s_acc, m_done, causes;

    assign s_acc  = s_tvalid && s_tready;
    assign m_done = m_tvalid && m_tready && m_tlast;
    assign causes = s_tlast || (open_reg && (s_tdata[COORD_BITS-1:0] != x_reg));

    // mirror of column state and owed items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg    <= 1'b0;
            x_reg       <= '0;
            pending_reg <= '0;
        end else begin
            if (s_acc) begin
                open_reg <= !s_tlast;
                x_reg    <= s_tdata[COORD_BITS-1:0];
            end
            pending_reg <= pending_reg + 4'(s_acc && causes) - 4'(m_done);
        end
    end

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // no result after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // no invented results
    a_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("result without an item that caused it");

    // owed items bounded by queue plus output stage
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 4'(QUEUE_DEPTH + 1))
        else $error("too many items owed");

endmodule

bind column_min_max_decimation_top cmmd_checker u_cmmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ sim/tb_column_min_max_decimation_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_min_max_decimation_top - stream check of column min/max decimation
// Feeds plot points (directed corner cases, then random columns and noise)
// through the input stream with random gaps. A local column tracker computes
// the decimated points each item should cause. The result stream is stalled at
// random, and every result is compared field by field with the oldest
// expected point.
// ----------------------------------------------------------------------------
module tb_column_min_max_decimation_top;
    import cmmd_pkg::*;

    localparam int RAND_ITEMS  = 340;
    localparam int IDLE_LIMIT  = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_GAP     = 18;

    // one input item plus its pacing
    typedef struct {
        coord_t      x;
        coord_t      y;
        logic        eos;
        int unsigned gap;
        bit          hold;
    } plot_point_t;

    // one decimated point
    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
    } emitted_point_t;

    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_tvalid = 1'b0;
    logic    s_tready;
    data_t   s_tdata = '0;      // [in_x, in_y] from the low bits up
    logic    s_tlast = 1'b0;    // end_of_stream
    logic    m_tvalid;
    logic    m_tready = 1'b0;
    data_t   m_tdata;           // [out_x, out_y] from the low bits up
    logic    m_tlast;           // last_of_run

    plot_point_t    point_q[$];
    emitted_point_t decimated_q[$];

    // column tracker
    coord_t col_x;
    coord_t col_low_y;
    coord_t col_high_y;
    coord_t col_latest_y;
    logic   col_open;

    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned gap_left       = 0;
    int unsigned stall_left     = 0;
    bit          send_quiet     = 1'b0;
    bit          recv_quiet     = 1'b0;

    column_min_max_decimation_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // emit low/high (when they differ) and latest of the open column
    function automatic void flush_open_column();
        if (col_low_y != col_high_y) begin
            decimated_q.push_back(emitted_point_t'{col_x, col_low_y, 1'b0});
            decimated_q.push_back(emitted_point_t'{col_x, col_high_y, 1'b0});
        end
        decimated_q.push_back(emitted_point_t'{col_x, col_latest_y, 1'b0});
        col_open = 1'b0;
    endfunction

    // expected points caused by one accepted item
    function automatic void decimate_point(input plot_point_t pt);
        int unsigned n_before;
        n_before = decimated_q.size();
        if (col_open && pt.x != col_x)
            flush_open_column();
        if (!col_open) begin
            col_x      = pt.x;
            col_low_y  = pt.y;
            col_high_y = pt.y;
            col_open   = 1'b1;
        end else if (pt.y < col_low_y) begin
            col_low_y = pt.y;
        end else if (pt.y > col_high_y) begin
            col_high_y = pt.y;
        end
        col_latest_y = pt.y;
        if (pt.eos)
            flush_open_column();
        if (decimated_q.size() > n_before)
            decimated_q[decimated_q.size() - 1].last = 1'b1;
    endfunction

    // queue one item; gaps come in bursty and quiet stretches
    function automatic void add_point(input coord_t x, input coord_t y, input logic eos,
                                      input bit hold);
        plot_point_t pt;
        if ($urandom_range(0, 29) == 0)
            send_quiet = !send_quiet;
        pt.x    = x;
        pt.y    = y;
        pt.eos  = eos;
        pt.hold = hold;
        pt.gap  = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        point_q.push_back(pt);
    endfunction

    // driver
    always @(posedge aclk) begin
        plot_point_t pt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pt.x   = coord_t'(s_tdata[COORD_BITS-1:0]);
                pt.y   = coord_t'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
                pt.eos = s_tlast;
                decimate_point(pt);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (point_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (point_q[0].hold && decimated_q.size() != 0) begin
                    // pause until every pending result has drained
                    s_tvalid <= 1'b0;
                end else begin
                    pt = point_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= data_t'({pt.y, pt.x});
                    s_tlast  <= pt.eos;
                    if (point_q.size() != 0)
                        gap_left = point_q[0].gap;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        emitted_point_t exp_pt;
        coord_t         got_x;
        coord_t         got_y;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_x = coord_t'(m_tdata[COORD_BITS-1:0]);
                got_y = coord_t'(m_tdata[2*COORD_BITS-1:COORD_BITS]);
                if (decimated_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected point x=%0d y=%0d last=%0b",
                                 $realtime, got_x, got_y, m_tlast);
                end else begin
                    exp_pt = decimated_q.pop_front();
                    if (got_x !== exp_pt.x || got_y !== exp_pt.y || m_tlast !== exp_pt.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: point mismatch exp x=%0d y=%0d last=%0b,",
                                      " got x=%0d y=%0d last=%0b"},
                                     $realtime, exp_pt.x, exp_pt.y, exp_pt.last,
                                     got_x, got_y, m_tlast);
                    end
                end
                if ($urandom_range(0, 29) == 0)
                    recv_quiet = !recv_quiet;
                stall_left = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // stimulus and end of run
    initial begin
        coord_t      cx;
        coord_t      base_y;
        coord_t      yv;
        int unsigned len;
        int unsigned y_mode;
        int unsigned n_items;
        logic        eos;

        col_x        = '0;
        col_low_y    = '0;
        col_high_y   = '0;
        col_latest_y = '0;
        col_open     = 1'b0;

        // lone point closed by the end mark
        add_point(16'sd0, 16'sd0, 1'b1, 1'b0);
        // extremes with ties, closed by a new x
        add_point(-16'sd32768, 16'sd5, 1'b0, 1'b0);
        add_point(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
        add_point(-16'sd32768, 16'sd32767, 1'b0, 1'b0);
        add_point(-16'sd32768, -16'sd32768, 1'b0, 1'b0);
        add_point(-16'sd32768, 16'sd32767, 1'b0, 1'b0);
        add_point(-16'sd32768, 16'sd3, 1'b0, 1'b0);
        // flat column: only the latest point comes out
        add_point(16'sd32767, 16'sd7, 1'b0, 1'b1);
        add_point(16'sd32767, 16'sd7, 1'b0, 1'b0);
        add_point(16'sd32767, 16'sd7, 1'b0, 1'b0);
        // latest repeats the highest, end mark on a joining point
        add_point(-16'sd1, -16'sd1, 1'b0, 1'b0);
        add_point(-16'sd1, 16'sd100, 1'b0, 1'b0);
        add_point(-16'sd1, 16'sd100, 1'b1, 1'b0);
        // new x with end mark: old column and lone point in one item
        add_point(16'sh5555, 16'shAAAA, 1'b0, 1'b0);
        add_point(16'sh5555, 16'sh5555, 1'b0, 1'b0);
        add_point(16'shAAAA, 16'sh5555, 1'b1, 1'b0);
        add_point(16'sd1, 16'sd2, 1'b0, 1'b0);
        add_point(16'sd2, 16'sd1, 1'b0, 1'b0);
        add_point(16'sd2, 16'sd1, 1'b1, 1'b0);
        // same x reopens after an end mark
        add_point(16'sd5, 16'sd9, 1'b1, 1'b0);
        add_point(16'sd5, 16'sd4, 1'b0, 1'b0);
        add_point(16'sd5, 16'sd8, 1'b1, 1'b1);

        // random columns, mostly well formed, some noise
        cx      = '0;
        n_items = 0;
        while (n_items < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                add_point(coord_t'($urandom()), coord_t'($urandom()),
                          logic'($urandom_range(0, 1)), 1'b0);
                n_items++;
            end else begin
                case ($urandom_range(0, 3))
                    0: cx = coord_t'($urandom());
                    1: cx = cx + 16'sd1;
                    2: cx = cx;
                    default: begin
                        case ($urandom_range(0, 3))
                            0: cx = -16'sd32768;
                            1: cx = 16'sd32767;
                            2: cx = 16'sd0;
                            default: cx = -16'sd1;
                        endcase
                    end
                endcase
                len    = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12)
                                                     : $urandom_range(1, 6);
                y_mode = $urandom_range(0, 2);
                base_y = coord_t'($urandom());
                for (int i = 0; i < len; i++) begin
                    case (y_mode)
                        0: yv = coord_t'($urandom());
                        1: yv = base_y + coord_t'($urandom_range(0, 2));
                        default: yv = base_y;
                    endcase
                    eos = (i == len - 1) ? ($urandom_range(0, 3) == 0)
                                         : ($urandom_range(0, 29) == 0);
                    add_point(cx, yv, eos, (n_items == 0) || ($urandom_range(0, 59) == 0));
                    n_items++;
                end
            end
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // sample on the falling edge so the driver's updates have settled
        while (point_q.size() != 0 || s_tvalid || decimated_q.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && decimated_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
